// ----- sv/ghc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ghc_pkg;

    // heading format: unsigned Q16 degrees
    localparam int HEAD_W = 25;
    localparam logic [HEAD_W-1:0] FULL_TURN     = 25'd23592960;
    localparam logic [HEAD_W-1:0] HALF_TURN     = 25'd11796480;
    localparam logic [HEAD_W-1:0] QUARTER_TURN  = 25'd5898240;
    localparam logic [HEAD_W-1:0] THREE_QUARTER = 25'd17694720;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_ENABLE       = 3'd0,
        CFG_MAGN_ENABLE       = 3'd1,
        CFG_GYRO_OFFSET       = 3'd2,
        CFG_GYRO_SCALE        = 3'd3,
        CFG_CORRECTION_WINDOW = 3'd4
    } cfg_index_t;

    // shared multiplier operand widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // CORDIC datapath
    localparam int CORDIC_W   = 28;
    localparam int ANGLE_W    = 26;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 22;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_ROUND,
        ST_ADD,
        ST_WRAP,
        ST_CSTART,
        ST_CORDIC,
        ST_CMP,
        ST_EMIT
    } ghc_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_FINAL,
        CS_DONE
    } cordic_state_t;

    typedef struct packed {
        logic               start;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } cordic_req_t;

    typedef struct packed {
        logic              done;
        logic [HEAD_W-1:0] angle;
    } cordic_rsp_t;

    // atan(2^-i) in Q16 degrees
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ghc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ghc_mul
    import ghc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic      [MUL_P_W-1:0] p
);

    logic [MUL_P_W-1:0] p_reg;
    logic [MUL_P_W-1:0] p_next;

    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- sv/ghc_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ghc_cordic
    import ghc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cordic_req_t req,
    output cordic_rsp_t      rsp
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    cordic_state_t state_reg, state_next;
    logic [STEP_W-1:0]          cnt_reg, cnt_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ANGLE_W-1:0]  z_reg, z_next;
    logic                       base_reg, base_next;
    logic [HEAD_W-1:0]          angle_reg, angle_next;

    logic signed [CORDIC_W-1:0] xs, ys, dx, dy;
    logic signed [ANGLE_W-1:0]  step_ang, a_sum;
    logic                       last_step;

    assign last_step = (cnt_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (req.start)
                begin
                    if (req.y == 16'sd0 || req.x == 16'sd0)
                        state_next = CS_DONE;
                    else
                        state_next = CS_ITER;
                end
            end
            CS_ITER:  if (last_step) state_next = CS_FINAL;
            CS_FINAL: state_next = CS_DONE;
            CS_DONE:  state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        xs = {{(CORDIC_W-16){req.x[15]}}, req.x};
        ys = {{(CORDIC_W-16){req.y[15]}}, req.y};
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        step_ang = ANGLE_W'(atan_q16(ATAN_IDX_W'(cnt_reg)));
        a_sum = z_reg + (base_reg ? $signed(ANGLE_W'(HALF_TURN)) : $signed(ANGLE_W'(0)));
        if (a_sum < 0)
            a_sum = a_sum + $signed(ANGLE_W'(FULL_TURN));
        if (a_sum >= $signed(ANGLE_W'(FULL_TURN)))
            a_sum = a_sum - $signed(ANGLE_W'(FULL_TURN));

        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        base_next  = base_reg;
        angle_next = angle_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (req.start)
                begin
                    // axis-aligned vectors bypass the rotation
                    if (req.y == 16'sd0)
                        angle_next = req.x[15] ? HALF_TURN : '0;
                    else if (req.x == 16'sd0)
                        angle_next = req.y[15] ? THREE_QUARTER : QUARTER_TURN;
                    // left half plane: rotate by 180 first
                    if (req.x[15])
                    begin
                        xs = -xs;
                        ys = -ys;
                    end
                    x_next    = xs <<< 8;
                    y_next    = ys <<< 8;
                    z_next    = '0;
                    base_next = req.x[15];
                    cnt_next  = '0;
                end
            end
            CS_ITER:
            begin
                if (!y_reg[CORDIC_W-1])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + step_ang;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - step_ang;
                end
                cnt_next = cnt_reg + STEP_W'(1);
            end
            CS_FINAL: angle_next = a_sum[HEAD_W-1:0];
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        base_reg  <= base_next;
        angle_reg <= angle_next;
    end

    always_comb
    begin
        rsp.done  = (state_reg == CS_DONE);
        rsp.angle = angle_reg;
    end

endmodule

`default_nettype wire

// ----- sv/gyro_heading_with_compass_reset.sv -----
// Gyro sample: accepted, then 3 multiplier passes, sum, round, add, wrap and output load;
//   ready again afterwards unless a held result blocks.
// Compass sample: CORDIC start, vectoring (one vectoring step per cycle), compare, and
//   output load when a correction follows; an axis-aligned vector skips the vectoring.
// Reset (rst_n, async, low): heading 0, both sources disabled, offset 60,
//   scale 146801, window 983040; output channel empty.
`timescale 1ns / 1ps
`default_nettype none

module gyro_heading_with_compass_reset
    import ghc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // sample input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  mode,
    input  wire logic signed [15:0]    rate_raw,
    input  wire logic [20:0]           elapsed,
    input  wire logic signed [15:0]    mag_x,
    input  wire logic signed [15:0]    mag_y,
    input  wire logic                  robot_still,

    // heading result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [HEAD_W-1:0]          heading,
    output logic                       from_compass
);

    localparam logic [60:0] ROUND_BIAS = 61'd1 << 27;

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; a write takes effect at once, so the
    // host must write only while no sample is in flight; the block does not enforce it.
    // ------------------------------------------------------------------
    logic              gyro_enable_reg;
    logic              magn_enable_reg;
    logic [15:0]       gyro_offset_reg;
    logic [23:0]       gyro_scale_reg;
    logic [HEAD_W-1:0] window_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_enable_reg <= 1'b0;
            magn_enable_reg <= 1'b0;
            gyro_offset_reg <= 16'd60;
            gyro_scale_reg  <= 24'd146801;
            window_reg      <= 25'd983040;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GYRO_ENABLE:       gyro_enable_reg <= cfg_data[0];
                CFG_MAGN_ENABLE:       magn_enable_reg <= cfg_data[0];
                CFG_GYRO_OFFSET:       gyro_offset_reg <= cfg_data[15:0];
                CFG_GYRO_SCALE:        gyro_scale_reg  <= cfg_data[23:0];
                CFG_CORRECTION_WINDOW: window_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    ghc_state_t state_reg, state_next;

    logic [15:0]        absdiff_reg, absdiff_next;   // |rate - offset|
    logic               neg_reg, neg_next;           // sign of the increment
    logic [20:0]        elapsed_reg, elapsed_next;
    logic signed [15:0] mag_x_reg, mag_x_next;
    logic signed [15:0] mag_y_reg, mag_y_next;
    logic               still_reg, still_next;
    logic [19:0]        hi_reg, hi_next;             // upper half of |diff|*scale
    logic [40:0]        lo_reg, lo_next;             // low partial product
    logic [60:0]        sum_reg, sum_next;           // full |increment| in Q44
    logic [32:0]        q_reg, q_next;               // rounded |increment| in Q16
    logic signed [35:0] h_reg, h_next;               // heading before wrap
    logic [HEAD_W-1:0]  heading_reg, heading_next;
    logic               compass_reg, compass_next;   // pending result source
    logic               out_valid_reg, out_valid_next;
    logic [HEAD_W-1:0]  out_heading_reg, out_heading_next;
    logic               out_compass_reg, out_compass_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic               in_xfer;
    logic               out_free;
    logic signed [16:0] diff;
    logic signed [16:0] diff_mag;
    logic [60:0]        sum_round;
    logic signed [35:0] head_ext, q_ext, full_ext, h_wrap, h_sat;
    logic signed [26:0] hx, ax, wx, win_hi, win_lo;
    logic               correct;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // shared multiplier: |diff| * scale, then two halves of that times elapsed
    ghc_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // iterative vectoring CORDIC for the compass angle
    ghc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // window compare, no wrap awareness
    always_comb
    begin
        hx      = {2'b00, heading_reg};
        ax      = {2'b00, crsp.angle};
        wx      = {2'b00, window_reg};
        win_hi  = ax + wx;
        win_lo  = ax - wx;
        correct = still_reg && (hx > win_hi || hx < win_lo);
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // a sample from a disabled source is taken and dropped
                    if (!mode && gyro_enable_reg)
                        state_next = ST_MUL1;
                    else if (mode && magn_enable_reg)
                        state_next = ST_CSTART;
                end
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_ADD;
            ST_ADD:    state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_EMIT;
            ST_CSTART: state_next = ST_CORDIC;
            ST_CORDIC: if (crsp.done) state_next = ST_CMP;
            ST_CMP:    state_next = correct ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake, multiplier operands, CORDIC start
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        creq.start = (state_reg == ST_CSTART);
        creq.x     = mag_x_reg;
        creq.y     = mag_y_reg;
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = gyro_scale_reg;
                mul_b = {5'b0, absdiff_reg};
            end
            ST_MUL2:
            begin
                mul_a = {4'b0, mul_p[19:0]};
                mul_b = elapsed_reg;
            end
            ST_MUL3:
            begin
                mul_a = {4'b0, hi_reg};
                mul_b = elapsed_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        diff      = {rate_raw[15], rate_raw} - {gyro_offset_reg[15], gyro_offset_reg};
        diff_mag  = diff[16] ? -diff : diff;
        sum_round = sum_reg + ROUND_BIAS;
        head_ext  = {11'b0, heading_reg};
        q_ext     = {3'b0, q_reg};
        full_ext  = {11'b0, FULL_TURN};

        // one wrap, then clamp to the range from zero to a full turn
        h_wrap = h_reg;
        if (h_reg < 0)
            h_wrap = h_reg + full_ext;
        else if (h_reg > full_ext)
            h_wrap = h_reg - full_ext;
        h_sat = h_wrap;
        if (h_wrap < 0)
            h_sat = '0;
        else if (h_wrap > full_ext)
            h_sat = full_ext;

        absdiff_next     = absdiff_reg;
        neg_next         = neg_reg;
        elapsed_next     = elapsed_reg;
        mag_x_next       = mag_x_reg;
        mag_y_next       = mag_y_reg;
        still_next       = still_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        sum_next         = sum_reg;
        q_next           = q_reg;
        h_next           = h_reg;
        heading_next     = heading_reg;
        compass_next     = compass_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_heading_next = out_heading_reg;
        out_compass_next = out_compass_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    absdiff_next = diff_mag[15:0];
                    neg_next     = diff[16];
                    elapsed_next = elapsed;
                    mag_x_next   = mag_x;
                    mag_y_next   = mag_y;
                    still_next   = robot_still;
                end
            end
            ST_MUL2:  hi_next  = mul_p[39:20];
            ST_MUL3:  lo_next  = mul_p[40:0];
            ST_SUM:   sum_next = {20'b0, lo_reg} + {mul_p[40:0], 20'b0};
            // round to nearest, ties away from zero (on the magnitude)
            ST_ROUND: q_next   = sum_round[60:28];
            ST_ADD:   h_next   = neg_reg ? head_ext - q_ext : head_ext + q_ext;
            ST_WRAP:
            begin
                heading_next = h_sat[HEAD_W-1:0];
                compass_next = 1'b0;
            end
            ST_CMP:
            begin
                if (correct)
                begin
                    heading_next = crsp.angle;
                    compass_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_heading_next = heading_reg;
                    out_compass_next = compass_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        absdiff_reg     <= absdiff_next;
        neg_reg         <= neg_next;
        elapsed_reg     <= elapsed_next;
        mag_x_reg       <= mag_x_next;
        mag_y_reg       <= mag_y_next;
        still_reg       <= still_next;
        hi_reg          <= hi_next;
        lo_reg          <= lo_next;
        sum_reg         <= sum_next;
        q_reg           <= q_next;
        h_reg           <= h_next;
        compass_reg     <= compass_next;
        out_heading_reg <= out_heading_next;
        out_compass_reg <= out_compass_next;
    end

    assign out_valid    = out_valid_reg;
    assign heading      = out_heading_reg;
    assign from_compass = out_compass_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg <= FULL_TURN)
        else $error("heading above a full turn");

    a_compass_below_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && from_compass |-> heading < FULL_TURN)
        else $error("compass result not below a full turn");

    a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        crsp.done |-> state_reg == ST_CORDIC)
        else $error("CORDIC finished outside the wait state");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && out_valid_reg && out_stall |=> state_reg == ST_EMIT)
        else $error("result left while output was still stalled");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the gyro/compass heading tracker.
// A short table of directed rows comes first. Configuration rows in the table are
// written only once the block is idle. Random phases follow, each with its own
// register setting. Every transfer on the result channel is checked against the
// oldest owed heading, from an in-bench predictor or a given table value, in order of arrival.
module tb_top;
    import ghc_pkg::*;

    localparam int CORDIC_STEPS   = 16;
    // compass path is the slowest item; the settle time covers it plus margin
    localparam int SETTLE_CYCLES  = CORDIC_STEPS + 10;
    // longest legal quiet stretch is the long receiver hold (LONG_HOLD)
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1850;
    localparam int PHASE_ITEMS    = 150;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 40;

    localparam logic MODE_GYRO    = 1'b0;
    localparam logic MODE_COMPASS = 1'b1;
    // top of the unmapped register indexes (5..7)
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    localparam longint TURN = longint'(FULL_TURN);

    // atan(2^-i) in Q16 degrees
    localparam logic [0:23][21:0] ATAN_DEG = {
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_GIVEN
    } check_kind_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] rate;
        logic [20:0]        elapsed;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic               still;
    } sample_t;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              from_compass;
    } result_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               s;
        check_kind_t           kind;
        result_t               res;
    } step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  mode;
    logic signed [15:0]    rate_raw;
    logic [20:0]           elapsed;
    logic signed [15:0]    mag_x;
    logic signed [15:0]    mag_y;
    logic                  robot_still;
    logic                  out_valid;
    logic                  out_stall;
    logic [HEAD_W-1:0]     heading;
    logic                  from_compass;

    // predictor copy of the registers and the heading
    bit                 gyro_on;
    bit                 magn_on;
    logic signed [15:0] offset_r;
    logic [23:0]        scale_r;
    logic [24:0]        window_r;
    longint             heading_r;

    result_t heading_q[$];     // headings still owed by the block
    result_t due;
    step_t   plan[$];          // directed table
    int      mismatches;
    int      used_items;       // samples transferred so far
    int      idle_cycles;
    bit      in_gaps_on;
    bit      out_gaps_on;
    bit      hold_req;         // ask the receiver for one long hold

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    gyro_heading_with_compass_reset #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .rate_raw     (rate_raw),
        .elapsed      (elapsed),
        .mag_x        (mag_x),
        .mag_y        (mag_y),
        .robot_still  (robot_still),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .heading      (heading),
        .from_compass (from_compass)
    );

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // vectoring CORDIC angle of (x, y), Q16 degrees over [0, 360)
    function automatic longint compass_deg(int x, int y);
        longint base = 0;
        longint z = 0;
        longint a;
        int     dx;
        int     dy;
        if (y == 0)
            return (x < 0) ? longint'(HALF_TURN) : 0;
        if (x == 0)
            return (y > 0) ? longint'(QUARTER_TURN) : longint'(THREE_QUARTER);
        // left half-plane: rotate by 180 first
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = longint'(HALF_TURN);
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG[i];
            end
        end
        a = base + z;
        if (a < 0)
            a = a + TURN;
        if (a >= TURN)
            a = a - TURN;
        return a;
    endfunction

    // advance the heading by one accepted sample; emits is set when a result follows
    task automatic predict_heading(input sample_t s, output bit emits, output result_t r);
        longint diff;
        longint prod;
        longint mag;
        longint q;
        longint h;
        longint a;
        longint w;
        emits = 1'b0;
        r = '0;
        if (s.mode == MODE_GYRO)
        begin
            if (gyro_on)
            begin
                diff = longint'($signed(s.rate)) - longint'(offset_r);
                prod = diff * longint'(scale_r) * longint'(s.elapsed);
                // Q44 -> Q16, round half away from zero
                mag  = (prod < 0) ? -prod : prod;
                q    = (mag + (longint'(1) <<< 27)) >>> 28;
                h    = heading_r + ((prod < 0) ? -q : q);
                // one wrap only, then clamp
                if (h < 0)
                    h = h + TURN;
                else if (h > TURN)
                    h = h - TURN;
                if (h < 0)
                    h = 0;
                if (h > TURN)
                    h = TURN;
                heading_r = h;
                emits = 1'b1;
                r.heading = h[HEAD_W-1:0];
                r.from_compass = 1'b0;
            end
        end
        else if (magn_on)
        begin
            a = compass_deg($signed(s.mx), $signed(s.my));
            w = longint'(window_r);
            // plain compare, no wrap awareness
            if (s.still && (heading_r > a + w || heading_r < a - w))
            begin
                heading_r = a;
                emits = 1'b1;
                r.heading = a[HEAD_W-1:0];
                r.from_compass = 1'b1;
            end
        end
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        step_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endtask

    task automatic add_row(input logic m, input int rate, input int el, input int mx,
                           input int my, input logic still, input check_kind_t kind,
                           input logic [HEAD_W-1:0] hd = '0, input logic fc = 1'b0);
        step_t row;
        row = '0;
        row.s.mode = m;
        row.s.rate = rate[15:0];
        row.s.elapsed = el[20:0];
        row.s.mx = mx[15:0];
        row.s.my = my[15:0];
        row.s.still = still;
        row.kind = kind;
        row.res.heading = hd;
        row.res.from_compass = fc;
        plan.push_back(row);
    endtask

    // one register transfer; the predictor takes the value when it lands
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_GYRO_ENABLE:       gyro_on = data[0];
            CFG_MAGN_ENABLE:       magn_on = data[0];
            CFG_GYRO_OFFSET:       offset_r = data[15:0];
            CFG_GYRO_SCALE:        scale_r = data[23:0];
            CFG_CORRECTION_WINDOW: window_r = data[24:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering, wait for every owed heading, then let a silent item finish
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (heading_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // offer one sample; returns at the edge of its transfer
    task automatic send_sample(input sample_t s, input check_kind_t kind, input result_t given);
        int      gap;
        bit      emits;
        result_t r;
        @(negedge clk);
        gap = in_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        mode = s.mode;
        rate_raw = s.rate;
        elapsed = s.elapsed;
        mag_x = s.mx;
        mag_y = s.my;
        robot_still = s.still;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        used_items++;
        predict_heading(s, emits, r);
        if (kind == CHK_GIVEN)
            heading_q.push_back(given);
        else if (kind == CHK_PREDICT && emits)
            heading_q.push_back(r);
    endtask

    function automatic sample_t make_sample();
        sample_t s;
        s.mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       s.rate = 16'($urandom);
            1:       s.rate = offset_r + 16'($urandom_range(0, 600)) - 16'sd300;
            2:       s.rate = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: s.rate = 16'($urandom_range(0, 2000)) - 16'sd1000;
        endcase
        case ($urandom_range(0, 3))
            0:       s.elapsed = 21'($urandom_range(0, 1048576));
            1:       s.elapsed = 21'($urandom_range(0, 65536));
            2:       s.elapsed = $urandom_range(0, 1) ? 21'd1048576 : 21'd0;
            default: s.elapsed = 21'($urandom_range(0, 4096));
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                s.mx = 16'($urandom);
                s.my = 16'($urandom);
            end
            1:
            begin
                // on an axis
                if ($urandom_range(0, 1))
                begin
                    s.mx = 16'($urandom);
                    s.my = '0;
                end
                else
                begin
                    s.mx = '0;
                    s.my = 16'($urandom);
                end
            end
            2:
            begin
                s.mx = 16'($urandom_range(0, 6)) - 16'sd3;
                s.my = 16'($urandom_range(0, 6)) - 16'sd3;
            end
            default:
            begin
                s.mx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                s.my = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
        endcase
        s.still = $urandom_range(0, 3) != 0;
        return s;
    endfunction

    // result checker: every transfer against the oldest owed heading
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (heading_q.size() == 0)
                report($sformatf("heading %0d arrived with nothing owed", heading));
            else
            begin
                due = heading_q.pop_front();
                if (heading !== due.heading)
                    report($sformatf("heading %0d, expected %0d", heading, due.heading));
                if (from_compass !== due.from_compass)
                    report($sformatf("from_compass %0b, expected %0b",
                                     from_compass, due.from_compass));
            end
        end
    end

    // receiver: per result a random stall when gaps are on, or one long hold on request
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
                hold = out_gaps_on ? $urandom_range(0, 3) : 0;
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold)
                    @(negedge clk);
                out_stall = 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    // watchdog: too long without any transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int                 phase;
        bit                 g_en;
        bit                 m_en;
        logic signed [15:0] off;
        logic [23:0]        scl;
        logic [24:0]        win;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_GYRO;
        rate_raw = '0;
        elapsed = '0;
        mag_x = '0;
        mag_y = '0;
        robot_still = 1'b0;
        idle_cycles = 0;
        mismatches = 0;
        used_items = 0;
        hold_req = 1'b0;
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;

        // reset state of the registers and heading
        gyro_on = 1'b0;
        magn_on = 1'b0;
        offset_r = 16'sd60;
        scale_r = 24'd146801;
        window_r = 25'd983040;
        heading_r = 0;

        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        // both sources disabled after reset: ignored
        add_row(MODE_GYRO, 32767, 1048576, 0, 0, 1'b1, CHK_NONE);
        add_row(MODE_COMPASS, 0, 0, 0, 100, 1'b1, CHK_NONE);
        // high data bits must be masked off
        add_reg(CFG_GYRO_ENABLE, 25'h1FFFFFF);
        add_reg(CFG_MAGN_ENABLE, 25'h1555555);
        // rate equal to offset, and zero elapsed: no movement
        add_row(MODE_GYRO, 60, 1048576, 0, 0, 1'b0, CHK_GIVEN, '0, 1'b0);
        add_row(MODE_GYRO, 1000, 0, 0, 0, 1'b0, CHK_GIVEN, '0, 1'b0);
        // axis-aligned compass vectors, heading far off
        add_row(MODE_COMPASS, 0, 0, 0, 100, 1'b1, CHK_GIVEN, QUARTER_TURN, 1'b1);
        add_row(MODE_COMPASS, 0, 0, 0, 100, 1'b0, CHK_NONE);    // moving
        add_row(MODE_COMPASS, 0, 0, 0, 50, 1'b1, CHK_NONE);     // already agrees
        add_row(MODE_COMPASS, 0, 0, -7, 0, 1'b1, CHK_GIVEN, HALF_TURN, 1'b1);
        add_row(MODE_COMPASS, 0, 0, 0, -1, 1'b1, CHK_GIVEN, THREE_QUARTER, 1'b1);
        add_row(MODE_COMPASS, 0, 0, 5, 0, 1'b1, CHK_GIVEN, '0, 1'b1);
        add_row(MODE_COMPASS, 0, 0, 0, 0, 1'b1, CHK_NONE);      // zero vector gives 0
        // full-scale rates, wrap both ways
        add_row(MODE_GYRO, 32767, 1048576, 0, 0, 1'b0, CHK_PREDICT);
        add_row(MODE_GYRO, -32768, 1048576, 0, 0, 1'b0, CHK_PREDICT);
        add_row(MODE_GYRO, 32767, 1048576, 0, 0, 1'b0, CHK_PREDICT);
        // diagonal extremes in all four quadrants, and a small diagonal
        add_row(MODE_COMPASS, 0, 0, 32767, 32767, 1'b1, CHK_PREDICT);
        add_row(MODE_COMPASS, 0, 0, -32768, -32768, 1'b1, CHK_PREDICT);
        add_row(MODE_COMPASS, 0, 0, -32768, 32767, 1'b1, CHK_PREDICT);
        add_row(MODE_COMPASS, 0, 0, 32767, -32768, 1'b1, CHK_PREDICT);
        add_row(MODE_COMPASS, 0, 0, 1, -1, 1'b1, CHK_PREDICT);
        // huge step up saturates at a full turn, which is then held
        add_reg(CFG_GYRO_OFFSET, 25'h1FF8000);
        add_reg(CFG_GYRO_SCALE, 25'h1FFFFFF);
        add_row(MODE_GYRO, 32767, 1048576, 0, 0, 1'b0, CHK_GIVEN, FULL_TURN, 1'b0);
        add_row(MODE_GYRO, 32767, 0, 0, 0, 1'b0, CHK_GIVEN, FULL_TURN, 1'b0);
        // huge step down saturates at zero
        add_reg(CFG_GYRO_OFFSET, 25'h0007FFF);
        add_row(MODE_GYRO, -32768, 1048576, 0, 0, 1'b0, CHK_GIVEN, '0, 1'b0);
        // zero window: exact match needs no correction
        add_reg(CFG_CORRECTION_WINDOW, 25'd0);
        add_row(MODE_COMPASS, 0, 0, 3, 0, 1'b1, CHK_NONE);
        add_row(MODE_COMPASS, 0, 0, 0, 9, 1'b1, CHK_GIVEN, QUARTER_TURN, 1'b1);
        // full-turn window: never corrects
        add_reg(CFG_CORRECTION_WINDOW, FULL_TURN);
        add_row(MODE_COMPASS, 0, 0, -1, 0, 1'b1, CHK_NONE);
        // zero scale, and a write to an unmapped index that must change nothing
        add_reg(CFG_GYRO_SCALE, 25'h1000000);
        add_reg(CFG_NO_REG, 25'd0);
        add_row(MODE_GYRO, -32768, 1048576, 0, 0, 1'b0, CHK_GIVEN, QUARTER_TURN, 1'b0);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_sample(plan[i].s, plan[i].kind, plan[i].res);
        end

        // random phases; phase 1 puts offset, scale, window at low end, phase 2 at high end
        phase = 1;
        while (used_items < ITEM_TARGET)
        begin
            drain();
            g_en = (phase <= 2) || ($urandom_range(0, 4) != 0);
            m_en = (phase <= 2) || ($urandom_range(0, 4) != 0);
            if (!g_en && !m_en)
                g_en = 1'b1;
            if (phase == 1)
                off = 16'sh8000;
            else if (phase == 2)
                off = 16'sh7FFF;
            else
                off = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 120));
            if (phase == 1)
                scl = '0;
            else if (phase == 2)
                scl = 24'hFFFFFF;
            else
                scl = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 400000));
            if (phase == 1)
                win = '0;
            else if (phase == 2)
                win = FULL_TURN;
            else
                win = ($urandom_range(0, 3) == 0) ? 25'($urandom_range(0, 23592960))
                                                  : 25'($urandom_range(0, 30 * 65536));
            write_reg(CFG_GYRO_ENABLE, {24'($urandom), g_en});
            write_reg(CFG_MAGN_ENABLE, {24'($urandom), m_en});
            write_reg(CFG_GYRO_OFFSET, {9'($urandom), off});
            write_reg(CFG_GYRO_SCALE, {1'($urandom), scl});
            write_reg(CFG_CORRECTION_WINDOW, win);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_NO_REG - 3'($urandom_range(0, 2)), 25'($urandom));

            in_gaps_on = $urandom_range(0, 3) != 0;
            out_gaps_on = $urandom_range(0, 3) != 0;
            for (int n = 0; n < PHASE_ITEMS && used_items < ITEM_TARGET; n++)
            begin
                // long receiver hold while samples keep coming: input must back up
                if (phase == 2 && n == 60)
                    hold_req = 1'b1;
                // sender pause mid-phase until every heading is in
                if (phase == 4 && n == 75)
                    drain();
                send_sample(make_sample(), CHK_PREDICT, '0);
            end
            phase++;
        end

        drain();
        if (mismatches == 0 && heading_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
